### src/brld_pkg.sv
// Shared types, constants and the symbol table for the bar run-length decoder.
// No dependencies; every other file imports this package.
package brld_pkg;

    localparam int CODE_W         = 16;
    localparam int CODE_BITS_DEF  = 12;
    localparam int POS_W          = 6;
    localparam int SMP_W          = 12;
    localparam int LEN_W          = 8;
    localparam int SYM_W          = 6;
    localparam int IDX_W          = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 12;

    // A drop in position larger than this is a wrap, so still forward travel.
    localparam logic [POS_W-1:0] WRAP_GAP = POS_W'(50);

    localparam logic [SMP_W-1:0] DARK_THR_RST  = SMP_W'(2048);
    localparam logic [SMP_W-1:0] LIGHT_THR_RST = SMP_W'(1024);
    localparam logic [LEN_W-1:0] ZERO_MIN_RST  = LEN_W'(1);
    localparam logic [LEN_W-1:0] ZERO_MAX_RST  = LEN_W'(4);
    localparam logic [LEN_W-1:0] ONE_MIN_RST   = LEN_W'(5);
    localparam logic [LEN_W-1:0] ONE_MAX_RST   = LEN_W'(9);
    localparam logic [LEN_W-1:0] MARK_MIN_RST  = LEN_W'(10);
    localparam logic [LEN_W-1:0] MARK_MAX_RST  = LEN_W'(18);
    localparam logic [LEN_W-1:0] LEN_SAT       = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_THR  = 3'd0,
        REG_LIGHT_THR = 3'd1,
        REG_ZERO_MIN  = 3'd2,
        REG_ZERO_MAX  = 3'd3,
        REG_ONE_MIN   = 3'd4,
        REG_ONE_MAX   = 3'd5,
        REG_MARK_MIN  = 3'd6,
        REG_MARK_MAX  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_DECODED  = 2'd0,
        ST_REJECTED = 2'd1,
        ST_BAD_LEN  = 2'd2
    } status_t;

    // Outcome of orienting and looking up a captured code.
    typedef struct packed {
        logic [CODE_W-1:0] raw_code;
        logic [SYM_W-1:0]  symbol_bits;
        logic [IDX_W-1:0]  symbol_index;
        logic              rejected;
    } sym_result_t;

    function automatic logic [IDX_W-1:0] sym_lookup(input logic [SYM_W-1:0] sym);
        logic [IDX_W-1:0] idx;
        case (sym)
            6'h07: idx = 5'd1;
            6'h0b: idx = 5'd2;
            6'h0d: idx = 5'd3;
            6'h0e: idx = 5'd4;
            6'h16: idx = 5'd5;
            6'h19: idx = 5'd6;
            6'h29: idx = 5'd7;
            6'h31: idx = 5'd8;
            6'h32: idx = 5'd9;
            6'h2a: idx = 5'd10;
            6'h15: idx = 5'd11;
            6'h13: idx = 5'd12;
            6'h23: idx = 5'd13;
            6'h25: idx = 5'd14;
            6'h26: idx = 5'd15;
            6'h1a: idx = 5'd16;
            6'h1c: idx = 5'd17;
            6'h2c: idx = 5'd18;
            6'h34: idx = 5'd19;
            6'h38: idx = 5'd20;
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage

### src/brld_symbol.sv
// Orients a captured shift code, picks the even-position bits and maps them
// through the symbol table. Depends on brld_pkg.
module brld_symbol
    import brld_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic [CODE_W-1:0] shift_code,
    input  logic              reverse,
    output sym_result_t       result
);

    logic [CODE_W-1:0] rev_code;
    logic [CODE_W-1:0] code;
    logic [7:0]        even;

    // Mirror the low CODE_BITS bits, clear the rest.
    always_comb begin
        for (int i = 0; i < CODE_W; i++) begin
            if (i < CODE_BITS) begin
                rev_code[i] = shift_code[CODE_BITS-1-i];
            end else begin
                rev_code[i] = 1'b0;
            end
        end
    end

    assign code = reverse ? rev_code : shift_code;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            even[i] = code[2*i];
        end
    end

    // Bit 12 or bit 14 set means the symbol does not fit: reject it.
    always_comb begin
        result.raw_code     = code;
        result.symbol_bits  = even[SYM_W-1:0];
        result.symbol_index = (even[7:SYM_W] == '0) ? sym_lookup(even[SYM_W-1:0]) : '0;
        result.rejected     = (result.symbol_index == '0);
    end

endmodule

### src/bar_run_length_decoder_unit.sv
// Top level of the bar run-length decoder: handshakes, configuration
// registers, run tracking and the result register. Uses brld_pkg, brld_symbol.
//
//   channel  | ports                              | direction | moves
//   ---------+------------------------------------+-----------+------------------------
//   s_       | s_valid s_ready s_disk_position    | in        | one position + sample
//            | s_adc_sample                       |           |
//   m_       | m_valid m_ready m_status ...       | out       | zero or one decode result
//   cfg_     | cfg_valid cfg_ready cfg_index      | in        | register write request
//            | cfg_data                           |           |
//
// A request is registered at its accepting edge. Its run, code and decode logic
// settles while it is held in the input register, and any result is registered
// into the output register when that is free. One request is taken every cycle unless a stall holds it.
// Reset (aresetn low, synchronous) empties both registers, clears run and
// code state and loads the register defaults. A stalled result holds the
// output register; the input register still drains while the output is free.
// cfg_ready is always high.
module bar_run_length_decoder_unit
    import brld_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [POS_W-1:0]      s_disk_position,
    input  logic [SMP_W-1:0]      s_adc_sample,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [SYM_W-1:0]      m_symbol_bits,
    output logic [IDX_W-1:0]      m_symbol_index,
    output logic [CODE_W-1:0]     m_raw_code,
    output logic                  m_moving_reverse,
    output logic [LEN_W-1:0]      m_bad_run_length,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SMP_W-1:0] dark_thr_reg, light_thr_reg;
    logic [LEN_W-1:0] zero_min_reg, zero_max_reg;
    logic [LEN_W-1:0] one_min_reg, one_max_reg;
    logic [LEN_W-1:0] mark_min_reg, mark_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_thr_reg  <= DARK_THR_RST;
            light_thr_reg <= LIGHT_THR_RST;
            zero_min_reg  <= ZERO_MIN_RST;
            zero_max_reg  <= ZERO_MAX_RST;
            one_min_reg   <= ONE_MIN_RST;
            one_max_reg   <= ONE_MAX_RST;
            mark_min_reg  <= MARK_MIN_RST;
            mark_max_reg  <= MARK_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_DARK_THR:  dark_thr_reg  <= cfg_data;
                REG_LIGHT_THR: light_thr_reg <= cfg_data;
                REG_ZERO_MIN:  zero_min_reg  <= cfg_data[LEN_W-1:0];
                REG_ZERO_MAX:  zero_max_reg  <= cfg_data[LEN_W-1:0];
                REG_ONE_MIN:   one_min_reg   <= cfg_data[LEN_W-1:0];
                REG_ONE_MAX:   one_max_reg   <= cfg_data[LEN_W-1:0];
                REG_MARK_MIN:  mark_min_reg  <= cfg_data[LEN_W-1:0];
                REG_MARK_MAX:  mark_max_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic             in_valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic [SMP_W-1:0] smp_reg;
    logic             m_valid_reg;
    logic             out_free;
    logic             fire;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pos_reg <= s_disk_position;
            smp_reg <= s_adc_sample;
        end
    end

    // ---------------------------------------------------------------
    // Run and code state
    // ---------------------------------------------------------------
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic              reverse_next;
    logic [LEN_W-1:0]  dark_run_reg, dark_run_next;
    logic [LEN_W-1:0]  light_run_reg, light_run_next;
    logic [CODE_W-1:0] shift_reg, shift_next;

    logic              is_dark, is_light;
    logic [LEN_W-1:0]  ended_len;
    logic              ended_dark;
    logic              in_zero, in_one, in_mark;
    logic              start_mark;
    logic              res_valid;
    status_t           res_status;
    logic [SYM_W-1:0]  res_sym;
    logic [IDX_W-1:0]  res_idx;
    logic [CODE_W-1:0] res_raw;
    logic [LEN_W-1:0]  res_bad;
    sym_result_t       sym_res;

    // Direction: rising position, or a drop past the wrap gap, is forward.
    // It is fixed anew by every request; only the output register keeps a copy of it.
    always_comb begin
        last_pos_next = pos_reg;
        if (pos_reg > last_pos_reg) begin
            reverse_next = 1'b0;
        end else if ((last_pos_reg - pos_reg) > WRAP_GAP) begin
            reverse_next = 1'b0;
        end else begin
            reverse_next = 1'b1;
        end
    end

    // Run tracking: a dark sample wins when both thresholds are met.
    assign is_dark  = (smp_reg >= dark_thr_reg);
    assign is_light = !is_dark && (smp_reg <= light_thr_reg);

    always_comb begin
        dark_run_next  = dark_run_reg;
        light_run_next = light_run_reg;
        ended_len      = '0;
        ended_dark     = 1'b0;
        if (is_dark) begin
            if (dark_run_reg != LEN_SAT) begin
                dark_run_next = dark_run_reg + LEN_W'(1);
            end
            if (light_run_reg != '0) begin
                ended_len      = light_run_reg;
                light_run_next = '0;
            end
        end else if (is_light) begin
            if (light_run_reg != LEN_SAT) begin
                light_run_next = light_run_reg + LEN_W'(1);
            end
            if (dark_run_reg != '0) begin
                ended_len     = dark_run_reg;
                ended_dark    = 1'b1;
                dark_run_next = '0;
            end
        end
    end

    // Orient and decode the code as it stands before this run is added.
    brld_symbol #(
        .CODE_BITS(CODE_BITS)
    ) u_symbol (
        .shift_code(shift_reg),
        .reverse   (reverse_next),
        .result    (sym_res)
    );

    assign in_zero = (ended_len >= zero_min_reg) && (ended_len <= zero_max_reg);
    assign in_one  = (ended_len >= one_min_reg)  && (ended_len <= one_max_reg);
    assign in_mark = (ended_len >= mark_min_reg) && (ended_len <= mark_max_reg);

    // Dark mark leads going forward, light mark leads in reverse.
    assign start_mark = reverse_next ? !ended_dark : ended_dark;

    // Class the ended run: zero range first, then one, then mark.
    always_comb begin
        shift_next = shift_reg;
        res_valid  = 1'b0;
        res_status = ST_BAD_LEN;
        res_sym    = '0;
        res_idx    = '0;
        res_raw    = '0;
        res_bad    = '0;
        if (ended_len != '0) begin
            if (in_zero) begin
                shift_next = {shift_reg[CODE_W-2:0], 1'b0};
            end else if (in_one) begin
                shift_next = {shift_reg[CODE_W-2:0], 1'b1};
            end else if (in_mark) begin
                shift_next = '0;
                if (!start_mark) begin
                    res_valid  = 1'b1;
                    res_status = sym_res.rejected ? ST_REJECTED : ST_DECODED;
                    res_sym    = sym_res.symbol_bits;
                    res_idx    = sym_res.symbol_index;
                    res_raw    = sym_res.raw_code;
                end
            end else begin
                // Length fits no class: report it and keep the code.
                res_valid = 1'b1;
                res_bad   = ended_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg  <= '0;
            dark_run_reg  <= '0;
            light_run_reg <= '0;
            shift_reg     <= '0;
        end else if (fire) begin
            last_pos_reg  <= last_pos_next;
            dark_run_reg  <= dark_run_next;
            light_run_reg <= light_run_next;
            shift_reg     <= shift_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [1:0]        status_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CODE_W-1:0] raw_reg;
    logic              dir_reg;
    logic [LEN_W-1:0]  bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            status_reg <= res_status;
            sym_reg    <= res_sym;
            idx_reg    <= res_idx;
            raw_reg    <= res_raw;
            dir_reg    <= reverse_next;
            bad_reg    <= res_bad;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_symbol_bits    = sym_reg;
    assign m_symbol_index   = idx_reg;
    assign m_raw_code       = raw_reg;
    assign m_moving_reverse = dir_reg;
    assign m_bad_run_length = bad_reg;

endmodule

### src/brld_checker.sv
// Port-level checks on the bar run-length decoder result channel, and the
// bind that attaches them to the top level. Depends on brld_pkg.
module brld_checker
    import brld_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_status,
    input logic [IDX_W-1:0]  m_symbol_index,
    input logic [CODE_W-1:0] m_raw_code,
    input logic [LEN_W-1:0]  m_bad_run_length
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_raw_code))
        else $error("result changed while stalled");

    a_decoded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DECODED |-> m_symbol_index != '0 && m_bad_run_length == '0)
        else $error("decoded result without index");

    a_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_REJECTED |-> m_symbol_index == '0 && m_bad_run_length == '0)
        else $error("rejected result carries index or length");

    a_bad_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_BAD_LEN |-> m_raw_code == '0 && m_symbol_index == '0
            && m_bad_run_length != '0)
        else $error("length error fields inconsistent");

endmodule

bind bar_run_length_decoder_unit brld_checker u_brld_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_symbol_index  (m_symbol_index),
    .m_raw_code      (m_raw_code),
    .m_bad_run_length(m_bad_run_length)
);

### bench/tb.sv
// Self-checking bench for bar_run_length_decoder_unit: drives samples, register writes and
// result backpressure, and checks every result against a predictor of the decoder.
// Depends on brld_pkg and the unit under test only.
import brld_pkg::*;

module tb;

    // Hard stop, far above the slowest legal run: at most ~8000 requests, each with the
    // longest sender gap and long receiver stalls, plus drain pauses between phases.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int ITEM_GOAL     = 1250;
    localparam int ITEM_CAP      = 8000;
    localparam int RESULT_GOAL   = 60;
    localparam int PHASE_BUDGET  = 40;
    localparam int SETTLE_CYCLES = 4;   // input and output register plus margin
    localparam int MAX_GAP       = 8;

    typedef struct packed {
        status_t           status;
        logic [SYM_W-1:0]  symbol_bits;
        logic [IDX_W-1:0]  symbol_index;
        logic [CODE_W-1:0] raw_code;
        logic              moving_reverse;
        logic [LEN_W-1:0]  bad_run_length;
    } decode_t;

    typedef enum int {SHADE_DARK, SHADE_LIGHT, SHADE_MID} shade_t;

    // Tracks direction, runs and the shift code; queues the decode each run end predicts.
    class decode_scoreboard;
        const logic [SYM_W-1:0] SYMBOLS [20] = '{
            6'h07, 6'h0b, 6'h0d, 6'h0e, 6'h16, 6'h19, 6'h29, 6'h31, 6'h32, 6'h2a,
            6'h15, 6'h13, 6'h23, 6'h25, 6'h26, 6'h1a, 6'h1c, 6'h2c, 6'h34, 6'h38};

        logic [SMP_W-1:0]  dark_thr, light_thr;
        logic [LEN_W-1:0]  zero_min, zero_max, one_min, one_max, mark_min, mark_max;
        logic [POS_W-1:0]  last_pos;
        logic              heading_rev;
        logic [LEN_W-1:0]  dark_run, light_run;
        logic [CODE_W-1:0] shift_code;
        decode_t           decode_q[$];
        int                mismatches;
        int                checked;

        function new();
            dark_thr    = DARK_THR_RST;
            light_thr   = LIGHT_THR_RST;
            zero_min    = ZERO_MIN_RST;
            zero_max    = ZERO_MAX_RST;
            one_min     = ONE_MIN_RST;
            one_max     = ONE_MAX_RST;
            mark_min    = MARK_MIN_RST;
            mark_max    = MARK_MAX_RST;
            last_pos    = '0;
            heading_rev = 1'b0;
            dark_run    = '0;
            light_run   = '0;
            shift_code  = '0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function int pending();
            return decode_q.size();
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DARK_THR:  dark_thr  = data;
                REG_LIGHT_THR: light_thr = data;
                REG_ZERO_MIN:  zero_min  = data[LEN_W-1:0];
                REG_ZERO_MAX:  zero_max  = data[LEN_W-1:0];
                REG_ONE_MIN:   one_min   = data[LEN_W-1:0];
                REG_ONE_MAX:   one_max   = data[LEN_W-1:0];
                REG_MARK_MIN:  mark_min  = data[LEN_W-1:0];
                REG_MARK_MAX:  mark_max  = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit in_band(logic [LEN_W-1:0] len, logic [LEN_W-1:0] lo,
                             logic [LEN_W-1:0] hi);
            return len >= lo && len <= hi;
        endfunction

        function logic [CODE_W-1:0] mirror_low(logic [CODE_W-1:0] c);
            logic [CODE_W-1:0] m;
            m = '0;
            for (int i = 0; i < CODE_BITS_DEF; i++) m[i] = c[CODE_BITS_DEF-1-i];
            return m;
        endfunction

        function logic [7:0] even_bits(logic [CODE_W-1:0] c);
            logic [7:0] e;
            for (int i = 0; i < 8; i++) e[i] = c[2*i];
            return e;
        endfunction

        function logic [IDX_W-1:0] table_index(logic [SYM_W-1:0] s);
            for (int i = 0; i < 20; i++) begin
                if (SYMBOLS[i] == s) return IDX_W'(i + 1);
            end
            return '0;
        endfunction

        function void close_run(logic [LEN_W-1:0] len, logic ended_dark);
            decode_t           r;
            logic [CODE_W-1:0] code;
            logic [7:0]        evens;
            r = '0;
            r.moving_reverse = heading_rev;
            if (in_band(len, zero_min, zero_max)) begin
                shift_code = {shift_code[CODE_W-2:0], 1'b0};
            end else if (in_band(len, one_min, one_max)) begin
                shift_code = {shift_code[CODE_W-2:0], 1'b1};
            end else if (in_band(len, mark_min, mark_max)) begin
                // leading mark: dark going forward, light in reverse
                if (heading_rev ^ ended_dark) begin
                    shift_code = '0;
                end else begin
                    code  = heading_rev ? mirror_low(shift_code) : shift_code;
                    evens = even_bits(code);
                    // a symbol spilling into bits 12 or 14 can never be in the table
                    r.symbol_index = (evens[7:6] == 2'b00) ? table_index(evens[5:0]) : '0;
                    r.status       = (r.symbol_index != '0) ? ST_DECODED : ST_REJECTED;
                    r.symbol_bits  = evens[5:0];
                    r.raw_code     = code;
                    decode_q.push_back(r);
                    shift_code = '0;
                end
            end else begin
                r.status         = ST_BAD_LEN;
                r.bad_run_length = len;
                decode_q.push_back(r);
            end
        endfunction

        function void note_sample(logic [POS_W-1:0] pos, logic [SMP_W-1:0] smp);
            logic [LEN_W-1:0] ended;
            logic             ended_dark;
            ended      = '0;
            ended_dark = 1'b0;
            if (pos > last_pos) heading_rev = 1'b0;
            else if (int'(last_pos) - int'(pos) > int'(WRAP_GAP)) heading_rev = 1'b0;
            else heading_rev = 1'b1;
            last_pos = pos;
            if (smp >= dark_thr) begin
                if (dark_run != LEN_SAT) dark_run++;
                if (light_run != '0) begin
                    ended     = light_run;
                    light_run = '0;
                end
            end else if (smp <= light_thr) begin
                if (light_run != LEN_SAT) light_run++;
                if (dark_run != '0) begin
                    ended      = dark_run;
                    ended_dark = 1'b1;
                    dark_run   = '0;
                end
            end
            if (ended != '0) close_run(ended, ended_dark);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function string show(decode_t d);
            return $sformatf("st=%0d sym=%h idx=%0d raw=%h rev=%b bad=%0d", d.status,
                             d.symbol_bits, d.symbol_index, d.raw_code, d.moving_reverse,
                             d.bad_run_length);
        endfunction

        task check_result(logic [1:0] st, logic [SYM_W-1:0] sym, logic [IDX_W-1:0] idx,
                          logic [CODE_W-1:0] raw, logic rev, logic [LEN_W-1:0] bad);
            decode_t got;
            decode_t want;
            string   diff;
            got.status         = status_t'(st);
            got.symbol_bits    = sym;
            got.symbol_index   = idx;
            got.raw_code       = raw;
            got.moving_reverse = rev;
            got.bad_run_length = bad;
            if (decode_q.size() == 0) begin
                report({"result with none expected: ", show(got)});
                return;
            end
            want = decode_q.pop_front();
            checked++;
            diff = "";
            if (st !== want.status)              diff = {diff, " status"};
            if (sym !== want.symbol_bits)        diff = {diff, " symbol_bits"};
            if (idx !== want.symbol_index)       diff = {diff, " symbol_index"};
            if (raw !== want.raw_code)           diff = {diff, " raw_code"};
            if (rev !== want.moving_reverse)     diff = {diff, " moving_reverse"};
            if (bad !== want.bad_run_length)     diff = {diff, " bad_run_length"};
            if (diff != "")
                report($sformatf("result %0d wrong:%s | got %s | want %s", checked, diff,
                                 show(got), show(want)));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [POS_W-1:0]      s_disk_position;
    logic [SMP_W-1:0]      s_adc_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [SYM_W-1:0]      m_symbol_bits;
    logic [IDX_W-1:0]      m_symbol_index;
    logic [CODE_W-1:0]     m_raw_code;
    logic                  m_moving_reverse;
    logic [LEN_W-1:0]      m_bad_run_length;
    logic                  cfg_valid;
    logic                  cfg_ready;
    reg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    decode_scoreboard sb = new();

    logic [POS_W-1:0] cur_pos;
    int idle_pct;       // chance in 100 that the sender sits out a cycle
    int stall_pct;      // chance in 100 that the receiver holds off a cycle
    int phase_idle;
    int phase_stall;
    int items_sent;
    int cycle_count;

    bar_run_length_decoder_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_disk_position  (s_disk_position),
        .s_adc_sample     (s_adc_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_symbol_bits    (m_symbol_bits),
        .m_symbol_index   (m_symbol_index),
        .m_raw_code       (m_raw_code),
        .m_moving_reverse (m_moving_reverse),
        .m_bad_run_length (m_bad_run_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result backpressure: redraw ready every cycle from the current stall rate.
    always @(posedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any hang ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Monitor: everything sampled here is the value the unit saw at this edge.
    // Retire results first, so a request accepted at the same edge queues behind them.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_status, m_symbol_bits, m_symbol_index, m_raw_code,
                                m_moving_reverse, m_bad_run_length);
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_sample(s_disk_position, s_adc_sample);
        end
    end

    // Send one request. Valid stays high from one request to the next unless a gap
    // is drawn, so it is never lowered and raised in the same step.
    task automatic send_item(input logic [POS_W-1:0] pos, input logic [SMP_W-1:0] smp);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_disk_position <= pos;
        s_adc_sample    <= smp;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Advance the disk in the given direction, now and then jump anywhere.
    task automatic send_at(input logic rev, input logic [SMP_W-1:0] smp);
        if ($urandom_range(49) == 0) cur_pos = POS_W'($urandom);
        else if (rev) cur_pos = cur_pos - POS_W'($urandom_range(2));
        else cur_pos = cur_pos + POS_W'($urandom_range(3, 1));
        send_item(cur_pos, smp);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SMP_W-1:0] pick_sample(shade_t shade);
        int dark_lo;
        int light_hi;
        int pick;
        dark_lo  = int'(sb.dark_thr);
        light_hi = (sb.light_thr < sb.dark_thr) ? int'(sb.light_thr) : dark_lo - 1;
        pick     = $urandom_range(9);
        case (shade)
            SHADE_DARK: begin
                if (pick == 0) return SMP_W'(dark_lo);
                if (pick == 1) return '1;
                return SMP_W'($urandom_range(4095, dark_lo));
            end
            SHADE_LIGHT: begin
                if (light_hi < 0) return '0;    // no light level exists
                if (pick == 0) return SMP_W'(light_hi);
                if (pick == 1) return '0;
                return SMP_W'($urandom_range(light_hi, 0));
            end
            default: begin
                if (light_hi + 1 <= dark_lo - 1)
                    return SMP_W'($urandom_range(dark_lo - 1, light_hi + 1));
                return SMP_W'($urandom);
            end
        endcase
    endfunction

    // Length inside a band; mostly short, the top only where it is cheap.
    function automatic int pick_len(logic [LEN_W-1:0] lo, logic [LEN_W-1:0] hi);
        if (lo > hi) return int'(lo);
        if (hi - lo <= 3) return $urandom_range(hi, lo);
        if (hi <= 20 && $urandom_range(4) == 0) return int'(hi);
        return int'(lo) + $urandom_range(3);
    endfunction

    task automatic emit_run(input shade_t shade, input int len, input logic rev);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) send_at(rev, pick_sample(SHADE_MID));
            send_at(rev, pick_sample(shade));
        end
    endtask

    function automatic shade_t flip(shade_t s);
        return (s == SHADE_DARK) ? SHADE_LIGHT : SHADE_DARK;
    endfunction

    // Leading mark, code bits as alternating runs, trailing mark. In reverse the
    // bits go out low first so the unit's bit reversal restores the code.
    task automatic send_frame(input logic rev, input bit valid_sym);
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  sym;
        logic              b;
        int                nbits;
        shade_t            s;
        code  = CODE_W'($urandom);
        sym   = valid_sym ? sb.SYMBOLS[$urandom_range(19)] : SYM_W'($urandom);
        for (int i = 0; i < SYM_W; i++) code[2*i] = sym[i];
        nbits = CODE_BITS_DEF;
        if (!rev && $urandom_range(3) == 0) nbits = $urandom_range(1) ? 16 : 14;
        else if ($urandom_range(7) == 0) nbits = 2 * $urandom_range(8, 1);
        s = rev ? SHADE_LIGHT : SHADE_DARK;
        emit_run(s, pick_len(sb.mark_min, sb.mark_max), rev);
        for (int i = 0; i < nbits; i++) begin
            b = rev ? code[i] : code[nbits-1-i];
            s = flip(s);
            emit_run(s, b ? pick_len(sb.one_min, sb.one_max)
                          : pick_len(sb.zero_min, sb.zero_max), rev);
        end
        emit_run(flip(s), pick_len(sb.mark_min, sb.mark_max), rev);
    endtask

    // Write all eight registers back to back, valid held high throughout.
    task automatic load_setting(input int kind);
        logic [CFG_DATA_W-1:0] v [8];
        int                    z, o, k;
        v[REG_DARK_THR]  = DARK_THR_RST;
        v[REG_LIGHT_THR] = LIGHT_THR_RST;
        v[REG_ZERO_MIN]  = CFG_DATA_W'(ZERO_MIN_RST);
        v[REG_ZERO_MAX]  = CFG_DATA_W'(ZERO_MAX_RST);
        v[REG_ONE_MIN]   = CFG_DATA_W'(ONE_MIN_RST);
        v[REG_ONE_MAX]   = CFG_DATA_W'(ONE_MAX_RST);
        v[REG_MARK_MIN]  = CFG_DATA_W'(MARK_MIN_RST);
        v[REG_MARK_MAX]  = CFG_DATA_W'(MARK_MAX_RST);
        case (kind)
            0: begin    // compact bands, many results
                v[REG_ZERO_MIN] = 1;  v[REG_ZERO_MAX] = 1;
                v[REG_ONE_MIN]  = 2;  v[REG_ONE_MAX]  = 2;
                v[REG_MARK_MIN] = 3;  v[REG_MARK_MAX] = 4;
            end
            2: begin    // threshold extremes, widest mark band
                v[REG_DARK_THR] = 4095; v[REG_LIGHT_THR] = 0;
                v[REG_ZERO_MIN] = 1;    v[REG_ZERO_MAX]  = 2;
                v[REG_ONE_MIN]  = 3;    v[REG_ONE_MAX]   = 4;
                v[REG_MARK_MIN] = 5;    v[REG_MARK_MAX]  = 255;
            end
            3: begin    // crossed thresholds, overlapping bands, length one is bad
                v[REG_DARK_THR] = 1000; v[REG_LIGHT_THR] = 4095;
                v[REG_ZERO_MIN] = 2;    v[REG_ZERO_MAX]  = 3;
                v[REG_ONE_MIN]  = 3;    v[REG_ONE_MAX]   = 5;
                v[REG_MARK_MIN] = 5;    v[REG_MARK_MAX]  = 7;
            end
            4: begin    // random small bands, sometimes shuffled or empty
                v[REG_DARK_THR]  = CFG_DATA_W'($urandom_range(4095, 1));
                v[REG_LIGHT_THR] = CFG_DATA_W'($urandom_range(4095));
                z = $urandom_range(3, 1);
                o = z + $urandom_range(2) + 1;
                k = o + $urandom_range(2) + 1;
                v[REG_ZERO_MIN] = CFG_DATA_W'(z); v[REG_ZERO_MAX] = CFG_DATA_W'(o - 1);
                v[REG_ONE_MIN]  = CFG_DATA_W'(o); v[REG_ONE_MAX]  = CFG_DATA_W'(k - 1);
                v[REG_MARK_MIN] = CFG_DATA_W'(k);
                v[REG_MARK_MAX] = CFG_DATA_W'(k + $urandom_range(3));
                if ($urandom_range(3) == 0) begin
                    for (int i = REG_ZERO_MIN; i <= REG_MARK_MAX; i++)
                        v[i] = CFG_DATA_W'($urandom_range(12, 1));
                end
            end
            5: begin    // marks only at the saturated length
                v[REG_DARK_THR] = 1;   v[REG_LIGHT_THR] = 0;
                v[REG_ZERO_MIN] = 1;   v[REG_ZERO_MAX]  = 1;
                v[REG_ONE_MIN]  = 2;   v[REG_ONE_MAX]   = 2;
                v[REG_MARK_MIN] = 255; v[REG_MARK_MAX]  = 255;
            end
            default: ;  // reset values, written explicitly
        endcase
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data  <= v[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest noise, broken
    // sequences and the odd saturating run. Pause once midway until all results are in.
    task automatic run_phase(input int budget);
        int stop_at;
        int pick;
        bit paused;
        stop_at = items_sent + budget;
        paused  = 1'b0;
        while (items_sent < stop_at) begin
            if ($urandom_range(4) == 0) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = phase_idle;
                stall_pct = phase_stall;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame($urandom_range(2) == 0, $urandom_range(4) != 0);
            end else if (pick < 85) begin
                repeat ($urandom_range(8, 1)) send_item(POS_W'($urandom), SMP_W'($urandom));
            end else if (pick < 97) begin
                repeat ($urandom_range(6, 1))
                    emit_run(shade_t'($urandom_range(1)), $urandom_range(24, 1),
                             1'($urandom_range(1)));
            end else begin
                emit_run(shade_t'($urandom_range(1)), 256 + $urandom_range(14),
                         1'($urandom_range(1)));
            end
            if (!paused && items_sent >= stop_at - budget / 2) begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    // Directed edge cases at reset values: position wrap and equality, a drop of
    // exactly 50 against 51, threshold-exact and in-between samples, field extremes.
    localparam logic [POS_W-1:0] DIR_POS [16] = '{
        6'd1, 6'd63, 6'd63, 6'd13, 6'd12, 6'd0, 6'd62, 6'd11,
        6'd0, 6'd63, 6'd0, 6'd42, 6'd21, 6'd21, 6'd22, 6'd23};
    localparam logic [SMP_W-1:0] DIR_SMP [16] = '{
        12'd4095, 12'd0, 12'd2048, 12'd1024, 12'd2047, 12'd1025, 12'd4095, 12'd0,
        12'd4095, 12'd0, 12'd4095, 12'd1234, 12'd3000, 12'd500, 12'd2048, 12'd1024};

    initial begin
        int phase;
        int kind;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_disk_position <= '0;
        s_adc_sample    <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_DARK_THR;
        cfg_data        <= '0;
        m_ready         <= 1'b0;
        cur_pos     = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        phase_idle  = 0;
        phase_stall = 0;
        items_sent  = 0;
        cycle_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 16; i++) send_item(DIR_POS[i], DIR_SMP[i]);
        cur_pos = DIR_POS[15];

        // Phase 0 runs on the reset values; each later phase loads a setting while idle.
        phase = 0;
        while ((phase < 7 || items_sent < ITEM_GOAL || sb.checked < RESULT_GOAL)
               && items_sent < ITEM_CAP) begin
            case (phase % 4)
                0: begin phase_idle = 0;  phase_stall = 0;  end
                1: begin phase_idle = 55; phase_stall = 0;  end
                2: begin phase_idle = 0;  phase_stall = 55; end
                default: begin phase_idle = 32; phase_stall = 32; end
            endcase
            if (phase > 0) begin
                kind = (phase - 1) % 6;
                settle();
                load_setting(kind);
                if (kind == 5) emit_run(SHADE_DARK, 300, 1'b0);
            end
            run_phase(PHASE_BUDGET);
            phase++;
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### bar_run_length_decoder_unit.f
src/brld_pkg.sv
src/brld_symbol.sv
src/bar_run_length_decoder_unit.sv
src/brld_checker.sv
bench/tb.sv
